FILE: hdl/sci_pkg.sv
// Package: state, status codes and opcodes for the sorted curve interpolator.
`default_nettype none
package sci_pkg;
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_UPDATED = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_EXACT   = 3'd3;
    localparam logic [2:0] ST_INTERP  = 3'd4;
    localparam logic [2:0] ST_NONE    = 3'd5;

    localparam logic [15:0] LIMIT_RESET = 16'd1024;
    localparam int          DIV_BITS    = 34;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_MUL,
        S_SUM,
        S_DIV,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

FILE: hdl/sorted_curve_interpolator_core.sv
// Top level: sorted point table in RAM with sequential scan, shift and divide.
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+-----------------------------
//  command  | i_opcode, i_x_value, i_y_value               | i_start taken when !o_busy
//  result   | o_curve_value, o_status, o_point_count       | o_done strobe, one cycle
//  config   | i_limit_wr, i_limit_data                     | written on any i_limit_wr
//
// Busy sequence per item: the scan reads, then compares, each point held (a match or an
// out-of-range lookup ends it early), then the done state. A new point adds a read and
// a write per point shifted up, then a write to place it; an interpolated lookup adds
// multiply and sum, then 34 radix-2 divide steps and rounding.
// Sync active low reset clears count and control and sets the limit to 1024; the RAM is not cleared.
// The receiver cannot stall: o_done strobes in the first cycle with o_busy low.
`default_nettype none
module sorted_curve_interpolator_core #(
    parameter int MAX_POINTS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    output logic                o_busy,
    input  wire                 i_opcode,
    input  wire signed [15:0]   i_x_value,
    input  wire signed [15:0]   i_y_value,
    input  wire                 i_limit_wr,
    input  wire        [15:0]   i_limit_data,
    output logic                o_done,
    output logic signed [15:0]  o_curve_value,
    output logic       [2:0]    o_status,
    output logic       [4:0]    o_point_count
);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DB = sci_pkg::DIV_BITS;

    // point RAM: {x, y}
    logic [31:0] r_mem [MAX_POINTS];
    logic [31:0] r_rd;
    logic        mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [31:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    sci_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pos, n_pos;
    logic [15:0]   r_limit;
    logic          r_op;
    logic signed [15:0] r_x, r_y;
    logic          r_have_lo, n_have_lo, r_have_hi, n_have_hi;
    logic signed [15:0] r_xlo, n_xlo, r_ylo, n_ylo, r_xhi, n_xhi, r_yhi, n_yhi;
    logic signed [33:0] r_p1, r_p2;
    logic          r_neg;
    logic [DB-1:0] r_quo;
    logic [17:0]   r_rem, r_den;
    logic [5:0]    r_bit;
    logic signed [15:0] r_val, n_val;
    logic [2:0]    r_st, n_st;
    logic          r_done;

    // scan compare on the registered read word
    logic signed [15:0] rd_x, rd_y;
    assign rd_x = r_rd[31:16];
    assign rd_y = r_rd[15:0];

    logic signed [34:0] sum;
    assign sum = 35'(r_p1) + 35'(r_p2);

    logic [18:0] trial;
    assign trial = {r_rem, r_quo[DB-1]} - {1'b0, r_den};

    logic in_range;
    assign in_range = !r_x[15] && ({1'b0, r_x} < {1'b0, r_limit});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sci_pkg::S_IDLE:    if (i_start) n_state = sci_pkg::S_SCAN_RD;
            sci_pkg::S_SCAN_RD: begin
                if (r_idx == r_cnt) begin
                    if (r_op == sci_pkg::OP_INSERT) begin
                        if (r_cnt >= CW'(MAX_POINTS)) n_state = sci_pkg::S_DONE;
                        else if (r_pos == r_cnt) n_state = sci_pkg::S_PUT;
                        else n_state = sci_pkg::S_SHIFT_RD;
                    end else if (!in_range || !r_have_lo || !r_have_hi) begin
                        n_state = sci_pkg::S_DONE;
                    end else begin
                        n_state = sci_pkg::S_MUL;
                    end
                end else if (r_op == sci_pkg::OP_LOOKUP && !in_range) begin
                    n_state = sci_pkg::S_DONE;
                end else begin
                    n_state = sci_pkg::S_SCAN;
                end
            end
            sci_pkg::S_SCAN:    n_state = (rd_x == r_x) ? sci_pkg::S_DONE : sci_pkg::S_SCAN_RD;
            sci_pkg::S_SHIFT_RD: n_state = sci_pkg::S_SHIFT_WR;
            sci_pkg::S_SHIFT_WR: n_state = (r_idx - 1'b1 == r_pos) ? sci_pkg::S_PUT
                                                              : sci_pkg::S_SHIFT_RD;
            sci_pkg::S_PUT:     n_state = sci_pkg::S_DONE;
            sci_pkg::S_MUL:     n_state = sci_pkg::S_SUM;
            sci_pkg::S_SUM:     n_state = sci_pkg::S_DIV;
            sci_pkg::S_DIV:     if (r_bit == 6'd0) n_state = sci_pkg::S_DONE;
            sci_pkg::S_DONE:    n_state = sci_pkg::S_IDLE;
            default:            n_state = sci_pkg::S_IDLE;
        endcase
    end

    // datapath / outputs
    logic [DB-1:0] q_rnd;
    always_comb begin
        n_cnt = r_cnt; n_idx = r_idx; n_pos = r_pos;
        n_have_lo = r_have_lo; n_have_hi = r_have_hi;
        n_xlo = r_xlo; n_ylo = r_ylo; n_xhi = r_xhi; n_yhi = r_yhi;
        n_val = r_val; n_st = r_st;
        mem_we = 1'b0; mem_wa = '0; mem_wd = '0;
        mem_ra = r_idx[AW-1:0];
        q_rnd = r_quo + DB'({r_rem, 1'b0} >= {1'b0, r_den});
        case (r_state)
            sci_pkg::S_IDLE: begin
                n_idx = '0; n_pos = r_cnt; n_have_lo = 1'b0; n_have_hi = 1'b0;
                n_val = 16'sd0;
                n_st = (i_opcode == sci_pkg::OP_INSERT) ? sci_pkg::ST_FULL
                                                        : sci_pkg::ST_NONE;
                if (i_opcode == sci_pkg::OP_LOOKUP) n_val = -16'sd1;
            end
            sci_pkg::S_SCAN_RD: begin
                if (r_idx == r_cnt && r_op == sci_pkg::OP_INSERT
                        && r_cnt < CW'(MAX_POINTS)) begin
                    n_st = sci_pkg::ST_STORED;
                    n_idx = r_cnt;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            sci_pkg::S_SCAN: begin
                n_idx = r_idx + 1'b1;
                if (rd_x == r_x) begin
                    if (r_op == sci_pkg::OP_INSERT) begin
                        mem_we = 1'b1; mem_wa = r_idx[AW-1:0]; mem_wd = {r_x, r_y};
                        n_st = sci_pkg::ST_UPDATED;
                    end else begin
                        n_val = rd_y; n_st = sci_pkg::ST_EXACT;
                    end
                end else if (rd_x < r_x) begin
                    n_have_lo = 1'b1; n_xlo = rd_x; n_ylo = rd_y;
                end else if (!r_have_hi) begin
                    n_have_hi = 1'b1; n_xhi = rd_x; n_yhi = rd_y;
                    n_pos = r_idx;
                end
            end
            sci_pkg::S_SHIFT_RD: mem_ra = AW'(r_idx - 1'b1);
            sci_pkg::S_SHIFT_WR: begin
                mem_we = 1'b1; mem_wa = r_idx[AW-1:0]; mem_wd = r_rd;
                n_idx = r_idx - 1'b1;
            end
            sci_pkg::S_PUT: begin
                mem_we = 1'b1; mem_wa = r_pos[AW-1:0]; mem_wd = {r_x, r_y};
            end
            sci_pkg::S_DIV: begin
                if (r_bit == 6'd0) begin
                    n_st = sci_pkg::ST_INTERP;
                    n_val = r_neg ? 16'(-q_rnd) : q_rnd[15:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sci_pkg::S_IDLE;
            r_cnt   <= '0;
            r_limit <= sci_pkg::LIMIT_RESET;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= (r_state == sci_pkg::S_DONE);
            if (i_limit_wr) r_limit <= i_limit_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_pos <= n_pos;
        r_have_lo <= n_have_lo; r_have_hi <= n_have_hi;
        r_xlo <= n_xlo; r_ylo <= n_ylo; r_xhi <= n_xhi; r_yhi <= n_yhi;
        r_val <= n_val; r_st <= n_st;
        if (r_state == sci_pkg::S_IDLE && i_start) begin
            r_op <= i_opcode; r_x <= i_x_value; r_y <= i_y_value;
        end
        if (r_state == sci_pkg::S_MUL) begin
            r_p1 <= 34'(r_ylo * (18'(r_xhi) - 18'(r_x)));
            r_p2 <= 34'(r_yhi * (18'(r_x) - 18'(r_xlo)));
            r_den <= 18'(18'(r_xhi) - 18'(r_xlo));
        end
        if (r_state == sci_pkg::S_SUM) begin
            r_neg <= sum[34];
            r_quo <= sum[34] ? DB'(-sum) : DB'(sum);
            r_rem <= '0;
            r_bit <= 6'(DB);
        end
        if (r_state == sci_pkg::S_DIV && r_bit != 6'd0) begin
            r_bit <= r_bit - 6'd1;
            if (!trial[18]) begin
                r_rem <= trial[17:0];
                r_quo <= {r_quo[DB-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[16:0], r_quo[DB-1]};
                r_quo <= {r_quo[DB-2:0], 1'b0};
            end
        end
    end

    assign o_busy        = (r_state != sci_pkg::S_IDLE);
    assign o_done        = r_done;
    assign o_curve_value = r_val;
    assign o_status      = r_st;
    assign o_point_count = 5'(r_cnt);

`ifndef NO_ASSERTIONS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_POINTS)) else $error("point count overflow");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("done while busy");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != $past(r_cnt)) |-> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("count changed by more than one");
    a_div_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sci_pkg::S_DIV) |-> (r_bit <= 6'(DB))) else $error("divider count");
`endif
endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// Testbench for the sorted curve interpolator core: directed table, random items, checks.
`default_nettype none
module tb_top;
    localparam int NUM_PTS   = 16;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1300;
    localparam int TAIL_WAIT = 120;

    typedef struct packed {
        logic        op;
        logic [15:0] x;
        logic [15:0] y;
    } t_cmd;

    typedef struct packed {
        logic [15:0] val;
        logic [2:0]  st;
        logic [4:0]  cnt;
    } t_answer;

    // directed row: the command, plus an optional typed-in answer
    typedef struct packed {
        t_cmd    cmd;
        logic    fixed;
        t_answer ans;
    } t_row;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        opcode = 1'b0;
    logic [15:0] x_in = '0;
    logic [15:0] y_in = '0;
    logic        lim_wr = 1'b0;
    logic [15:0] lim_data = '0;
    wire         busy, done;
    wire  [15:0] curve_out;
    wire  [2:0]  status_out;
    wire  [4:0]  count_out;

    sorted_curve_interpolator_core #(.MAX_POINTS(NUM_PTS)) i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_opcode(opcode), .i_x_value(x_in), .i_y_value(y_in),
        .i_limit_wr(lim_wr), .i_limit_data(lim_data),
        .o_done(done), .o_curve_value(curve_out), .o_status(status_out),
        .o_point_count(count_out)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state: sorted curve table and the range limit.
    int          tbl_x [NUM_PTS];
    int          tbl_y [NUM_PTS];
    int          tbl_n;
    int          range_limit;
    t_answer     answers_due[$];
    int          fail_cnt = 0;
    int          idle_cycles = 0;
    bit          no_gaps = 1'b0;

    function automatic t_answer curve_predict(t_cmd c);
        t_answer a;
        int xs, ys, pos, i;
        bit lo_ok, hi_ok, hit;
        longint xlo, ylo, xhi, yhi, sum, d, mag, q, r;
        xs = $signed(c.x);
        ys = $signed(c.y);
        a.val = 16'hFFFF;
        hit = 1'b0;
        if (c.op == sci_pkg::OP_INSERT) begin
            a.val = '0;
            for (i = 0; i < tbl_n; i++)
                if (!hit && tbl_x[i] == xs) begin
                    tbl_y[i] = ys;
                    hit = 1'b1;
                end
            if (hit) a.st = sci_pkg::ST_UPDATED;
            else if (tbl_n >= NUM_PTS) a.st = sci_pkg::ST_FULL;
            else begin
                pos = tbl_n;
                for (i = tbl_n - 1; i >= 0; i--)
                    if (tbl_x[i] > xs) pos = i;
                for (i = tbl_n; i > pos; i--) begin
                    tbl_x[i] = tbl_x[i-1];
                    tbl_y[i] = tbl_y[i-1];
                end
                tbl_x[pos] = xs;
                tbl_y[pos] = ys;
                tbl_n++;
                a.st = sci_pkg::ST_STORED;
            end
        end else begin
            a.st = sci_pkg::ST_NONE;
            if (xs >= 0 && xs < range_limit) begin
                lo_ok = 1'b0; hi_ok = 1'b0;
                xlo = 0; ylo = 0; xhi = 0; yhi = 0;
                for (i = 0; i < tbl_n; i++) begin
                    if (hit) continue;
                    if (tbl_x[i] == xs) begin
                        hit = 1'b1;
                        a.val = tbl_y[i][15:0];
                        a.st = sci_pkg::ST_EXACT;
                    end else if (tbl_x[i] < xs) begin
                        lo_ok = 1'b1; xlo = tbl_x[i]; ylo = tbl_y[i];
                    end else if (!hi_ok) begin
                        hi_ok = 1'b1; xhi = tbl_x[i]; yhi = tbl_y[i];
                    end
                end
                if (!hit && lo_ok && hi_ok) begin
                    sum = ylo * (xhi - xs) + yhi * (xs - xlo);
                    d = xhi - xlo;
                    mag = (sum < 0) ? -sum : sum;
                    q = mag / d;
                    r = mag % d;
                    if (2 * r >= d) q++;
                    if (sum < 0) q = -q;
                    a.val = q[15:0];
                    a.st = sci_pkg::ST_INTERP;
                end
            end
        end
        a.cnt = tbl_n[4:0];
        return a;
    endfunction

    // Result checker: strobe sampled at the edge that accepts it.
    always @(posedge clk) begin
        t_answer e;
        if (rst_n && done) begin
            if (answers_due.size() == 0) begin
                $error("result with nothing expected: val=%0h st=%0d cnt=%0d",
                       curve_out, status_out, count_out);
                fail_cnt++;
            end else begin
                e = answers_due.pop_front();
                if (curve_out !== e.val) begin
                    $error("curve_value exp %0h got %0h", e.val, curve_out);
                    fail_cnt++;
                end
                if (status_out !== e.st) begin
                    $error("status exp %0d got %0d", e.st, status_out);
                    fail_cnt++;
                end
                if (count_out !== e.cnt) begin
                    $error("point_count exp %0d got %0d", e.cnt, count_out);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: cycles with no item taken and no result.
    always @(posedge clk) begin
        if ((start && !busy) || done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Issue one item; optional random gap first. Start stays high across items unless a gap is taken.
    task automatic issue_item(t_cmd c, bit fixed, t_answer fixed_ans);
        t_answer p;
        if (!no_gaps)
            while ($urandom_range(99) < 21) begin
                start <= 1'b0;
                @(posedge clk);
            end
        start  <= 1'b1;
        opcode <= c.op;
        x_in   <= c.x;
        y_in   <= c.y;
        @(posedge clk);
        while (busy) @(posedge clk);
        // accepted at this edge
        p = curve_predict(c);
        if (fixed && p !== fixed_ans) begin
            $error("directed row disagrees: val exp %0h got %0h", fixed_ans.val, p.val);
            fail_cnt++;
        end
        answers_due.push_back(fixed ? fixed_ans : p);
    endtask

    // Wait until everything is back, then a margin, before a config write.
    task automatic drain_then_write(int lim);
        start <= 1'b0;
        @(posedge clk);
        while (answers_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        lim_wr   <= 1'b1;
        lim_data <= lim[15:0];
        @(posedge clk);
        lim_wr   <= 1'b0;
        range_limit = lim;
    endtask

    function automatic t_cmd mk(logic op, int x, int y);
        t_cmd c;
        c.op = op; c.x = x[15:0]; c.y = y[15:0];
        return c;
    endfunction

    function automatic t_answer ans(int v, logic [2:0] st, int n);
        t_answer a;
        a.val = v[15:0]; a.st = st; a.cnt = n[4:0];
        return a;
    endfunction

    function automatic int pick_x(int spread);
        return $urandom_range(spread) - 8;
    endfunction

    t_row directed[$];
    t_cmd rc;
    int   k, phase, spread;

    initial begin
        tbl_n = 0;
        range_limit = sci_pkg::LIMIT_RESET;
        // Directed table: empty lookups, extremes, exact, interpolate, rounding, update, full.
        directed.push_back('{mk(sci_pkg::OP_LOOKUP, 5, 0), 1'b1,
                             ans(-1, sci_pkg::ST_NONE, 0)});
        directed.push_back('{mk(sci_pkg::OP_LOOKUP, -1, 0), 1'b1,
                             ans(-1, sci_pkg::ST_NONE, 0)});
        directed.push_back('{mk(sci_pkg::OP_LOOKUP, 1024, 0), 1'b1,
                             ans(-1, sci_pkg::ST_NONE, 0)});
        directed.push_back('{mk(sci_pkg::OP_INSERT, 0, 32767), 1'b1,
                             ans(0, sci_pkg::ST_STORED, 1)});
        directed.push_back('{mk(sci_pkg::OP_INSERT, 1023, -32768), 1'b1,
                             ans(0, sci_pkg::ST_STORED, 2)});
        directed.push_back('{mk(sci_pkg::OP_INSERT, -32768, 1), 1'b1,
                             ans(0, sci_pkg::ST_STORED, 3)});
        directed.push_back('{mk(sci_pkg::OP_INSERT, 32767, -1), 1'b1,
                             ans(0, sci_pkg::ST_STORED, 4)});
        directed.push_back('{mk(sci_pkg::OP_LOOKUP, 0, 0), 1'b1,
                             ans(32767, sci_pkg::ST_EXACT, 4)});
        directed.push_back('{mk(sci_pkg::OP_LOOKUP, 1023, 0), 1'b1,
                             ans(-32768, sci_pkg::ST_EXACT, 4)});
        directed.push_back('{mk(sci_pkg::OP_LOOKUP, 511, 0), 1'b0, '0});
        directed.push_back('{mk(sci_pkg::OP_LOOKUP, 512, -1), 1'b0, '0});
        directed.push_back('{mk(sci_pkg::OP_INSERT, 10, -3), 1'b1,
                             ans(0, sci_pkg::ST_STORED, 5)});
        directed.push_back('{mk(sci_pkg::OP_INSERT, 14, 0), 1'b1,
                             ans(0, sci_pkg::ST_STORED, 6)});
        // half-way rounding on both signs
        directed.push_back('{mk(sci_pkg::OP_LOOKUP, 12, 0), 1'b1,
                             ans(-2, sci_pkg::ST_INTERP, 6)});
        directed.push_back('{mk(sci_pkg::OP_LOOKUP, 13, 0), 1'b1,
                             ans(-1, sci_pkg::ST_INTERP, 6)});
        directed.push_back('{mk(sci_pkg::OP_INSERT, 10, 3), 1'b1,
                             ans(0, sci_pkg::ST_UPDATED, 6)});
        directed.push_back('{mk(sci_pkg::OP_LOOKUP, 12, 0), 1'b1,
                             ans(2, sci_pkg::ST_INTERP, 6)});
        for (k = 0; k < 10; k++)
            directed.push_back('{mk(sci_pkg::OP_INSERT, 100 + 7 * k, k * 1000 - 4000),
                                 1'b0, '0});
        // table is full now: new x refused, existing x still updates
        directed.push_back('{mk(sci_pkg::OP_INSERT, 500, 5), 1'b1,
                             ans(0, sci_pkg::ST_FULL, 16)});
        directed.push_back('{mk(sci_pkg::OP_INSERT, 14, 9), 1'b1,
                             ans(0, sci_pkg::ST_UPDATED, 16)});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            issue_item(directed[i].cmd, directed[i].fixed, directed[i].ans);

        // Random phases: each starts from a cleared-by-reset-free table state, so
        // table contents carry over; limit changes between phases, extremes included.
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: drain_then_write(0);
                1: drain_then_write(32768);
                2: drain_then_write(65535);
                3: drain_then_write(1);
                4: drain_then_write($urandom_range(40, 300));
                default: drain_then_write(sci_pkg::LIMIT_RESET);
            endcase
            no_gaps = (phase == 2);
            spread = (phase == 3) ? 30 : 400;
            for (k = 0; k < N_RANDOM / 6; k++) begin
                rc.op = ($urandom_range(99) < 55) ? sci_pkg::OP_LOOKUP : sci_pkg::OP_INSERT;
                case ($urandom_range(9))
                    0: rc.x = 16'($urandom);
                    1: rc.x = 16'h8000 ^ ($urandom_range(1) ? 16'h0 : 16'hFFFF);
                    default: rc.x = 16'(pick_x(spread));
                endcase
                rc.y = 16'($urandom);
                if ($urandom_range(3) == 0) rc.y = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                issue_item(rc, 1'b0, '0);
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (answers_due.size() != 0) @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (fail_cnt == 0 && answers_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
